// ===== rtl/pth_pkg.sv =====
// ----------------------------------------------------------------------------
// pth_pkg
// Shared widths, register codes, reset values and types for the pad trigger
// with hysteresis and debounce.
// ----------------------------------------------------------------------------
package pth_pkg;

	// field widths
	localparam int PadW   = 2;
	localparam int SmpW   = 10;
	localparam int TimeW  = 32;
	localparam int DebW   = 8;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 10;

	// number of pads with a threshold register
	localparam int ThrRegs = 4;

	// defaults for top level parameters
	localparam int DefPadCount  = 4;
	localparam int DefSampleBits = 10;

	// register indexes
	localparam logic [CfgIdxW-1:0] REG_PAD0_THR   = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_PAD1_THR   = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_PAD2_THR   = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_PAD3_THR   = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_MARGIN     = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_DEBOUNCE   = 3'd5;

	// register reset values
	localparam logic [SmpW-1:0] RST_PAD0_THR = 10'd480;
	localparam logic [SmpW-1:0] RST_PAD1_THR = 10'd550;
	localparam logic [SmpW-1:0] RST_PAD2_THR = 10'd530;
	localparam logic [SmpW-1:0] RST_PAD3_THR = 10'd420;
	localparam logic [SmpW-1:0] RST_MARGIN   = 10'd170;
	localparam logic [DebW-1:0] RST_DEBOUNCE = 8'd5;

	// configuration as seen by the datapath
	typedef struct packed {
		logic [ThrRegs-1:0][SmpW-1:0] thresh;
		logic [SmpW-1:0]              margin;
		logic [DebW-1:0]              debounce;
	} pth_cfg_t;

	// one toggle result
	typedef struct packed {
		logic [PadW-1:0] pad_id;
		logic            note_on;
		logic [SmpW-1:0] level;
	} pth_res_t;

endpackage

// ===== rtl/pth_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pth_cfg_regs
// Configuration register file: four pad thresholds, release margin and
// debounce time, written through the configuration channel.
// ----------------------------------------------------------------------------
module pth_cfg_regs
	import pth_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [CfgIdxW-1:0] wr_index,
	input  logic [CfgDataW-1:0] wr_data,
	output pth_cfg_t           cfg
);

	logic [ThrRegs-1:0][SmpW-1:0] thresh_q;
	logic [SmpW-1:0]              margin_q;
	logic [DebW-1:0]              debounce_q;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q[0] <= RST_PAD0_THR;
			thresh_q[1] <= RST_PAD1_THR;
			thresh_q[2] <= RST_PAD2_THR;
			thresh_q[3] <= RST_PAD3_THR;
			margin_q    <= RST_MARGIN;
			debounce_q  <= RST_DEBOUNCE;
		end else if (wr_en) begin
			case (wr_index)
				REG_PAD0_THR: thresh_q[0] <= wr_data[SmpW-1:0];
				REG_PAD1_THR: thresh_q[1] <= wr_data[SmpW-1:0];
				REG_PAD2_THR: thresh_q[2] <= wr_data[SmpW-1:0];
				REG_PAD3_THR: thresh_q[3] <= wr_data[SmpW-1:0];
				REG_MARGIN:   margin_q    <= wr_data[SmpW-1:0];
				REG_DEBOUNCE: debounce_q  <= wr_data[DebW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.thresh   = thresh_q;
	assign cfg.margin   = margin_q;
	assign cfg.debounce = debounce_q;

endmodule

// ===== rtl/pth_core.sv =====
// ----------------------------------------------------------------------------
// pth_core
// Hysteresis compare and debounce decision for one registered sample, with
// the per-pad note flags and the last firing time.
// ----------------------------------------------------------------------------
module pth_core
	import pth_pkg::*;
#(
	parameter int PAD_COUNT   = DefPadCount,
	parameter int SAMPLE_BITS = DefSampleBits
)(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [PadW-1:0]  pad,
	input  logic [SmpW-1:0]  sample,
	input  logic [TimeW-1:0] now,
	input  pth_cfg_t         cfg,
	output logic             res_valid,
	output pth_res_t         res
);

	localparam logic [SmpW-1:0] SmpMask =
		(SAMPLE_BITS >= SmpW) ? {SmpW{1'b1}} : SmpW'((1 << SAMPLE_BITS) - 1);

	logic [PAD_COUNT-1:0] note_q;
	logic [TimeW-1:0]     last_fire_q;

	logic             pad_ok;
	logic [SmpW-1:0]  smp;
	logic [SmpW-1:0]  thr;
	logic [SmpW-1:0]  low;
	logic             cur_note;
	logic             fire;
	logic [TimeW-1:0] elapsed;
	logic             accept;

	// pad check, threshold lookup and release level
	assign pad_ok = (TimeW'(pad) < TimeW'(PAD_COUNT));
	assign smp    = sample & SmpMask;
	assign thr    = cfg.thresh[pad];
	assign low    = (thr > cfg.margin) ? (thr - cfg.margin) : '0;

	// current note of the selected pad
	always_comb begin
		cur_note = 1'b0;
		for (int k = 0; k < PAD_COUNT; k++) begin
			if (int'(pad) == k) cur_note = note_q[k];
		end
	end

	// hysteresis compare and debounce window
	assign fire    = pad_ok && (cur_note ? (smp < low) : (smp >= thr));
	assign elapsed = now - last_fire_q;
	assign accept  = fire && (elapsed > TimeW'(cfg.debounce));

	assign res_valid   = accept;
	assign res.pad_id  = pad;
	assign res.note_on = ~cur_note;
	assign res.level   = smp;

	// state update when the sample leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			note_q      <= '0;
			last_fire_q <= '0;
		end else if (step) begin
			if (fire) last_fire_q <= now;
			for (int k = 0; k < PAD_COUNT; k++) begin
				if (accept && int'(pad) == k) note_q[k] <= ~note_q[k];
			end
		end
	end

endmodule

// ===== rtl/pad_trigger_hysteresis_unit.sv =====
// ----------------------------------------------------------------------------
// pad_trigger_hysteresis_unit
// Force pad trigger: hysteresis comparator with debounce, one sample per
// transfer, zero or one note toggle out per sample.
// ----------------------------------------------------------------------------
//  channel  | signals                                  | direction
//  ---------+------------------------------------------+----------
//  in       | in_valid, in_ready, pad_index, sample,   | into block
//           | time_ms                                  |
//  out      | out_valid, out_ready, pad_id, note_on,   | out of block
//           | level                                    |
//  cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data| into block
//
// One sample per cycle sustained while results are taken; a result passes
// through the input register, then the result register.
// The note flags and last firing time update in the same edge that moves a
// sample into the result register, so the next sample sees them at once.
// Reset clears notes to off, last firing time to zero, registers to defaults.
// A stalled result holds the input register; in_ready then drops until the
// result is taken. cfg_ready is always high.
// ----------------------------------------------------------------------------
module pad_trigger_hysteresis_unit
	import pth_pkg::*;
#(
	parameter int PAD_COUNT   = DefPadCount,
	parameter int SAMPLE_BITS = DefSampleBits
)(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [PadW-1:0]     pad_index,
	input  logic [SmpW-1:0]     sample,
	input  logic [TimeW-1:0]    time_ms,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [PadW-1:0]     pad_id,
	output logic                note_on,
	output logic [SmpW-1:0]     level,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	pth_cfg_t cfg;

	logic             valid_s1;
	logic [PadW-1:0]  pad_s1;
	logic [SmpW-1:0]  sample_s1;
	logic [TimeW-1:0] time_s1;

	logic             advance;
	logic             res_valid;
	pth_res_t         res;
	logic             out_valid_q;
	pth_res_t         res_q;

	// configuration registers
	assign cfg_ready = 1'b1;

	pth_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// stage handshake
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pad_s1    <= pad_index;
			sample_s1 <= sample;
			time_s1   <= time_ms;
		end
	end

	// decision logic and pad state
	pth_core #(
		.PAD_COUNT   (PAD_COUNT),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.pad       (pad_s1),
		.sample    (sample_s1),
		.now       (time_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) res_q <= res;
	end

	assign out_valid = out_valid_q;
	assign pad_id    = res_q.pad_id;
	assign note_on   = res_q.note_on;
	assign level     = res_q.level;

endmodule

// ===== rtl/pth_checker.sv =====
// ----------------------------------------------------------------------------
// pth_checker
// Port level checks for the pad trigger: result hold, note alternation per
// pad, result latency and configuration readiness.
// ----------------------------------------------------------------------------
module pth_checker
	import pth_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic [PadW-1:0]  pad_id,
	input logic             note_on,
	input logic [SmpW-1:0]  level,
	input logic             cfg_ready
);

	logic [(1 << PadW)-1:0] seen_note_q;

	// last note state shown for each pad
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_note_q <= '0;
		end else if (out_valid && out_ready) begin
			seen_note_q[pad_id] <= note_on;
		end
	end

	// a stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pad_id) && $stable(note_on)
			&& $stable(level))
		else $error("result changed while stalled");

	// each transfer of a pad flips that pad's note
	a_alternate: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |-> note_on != seen_note_q[pad_id])
		else $error("note state did not toggle");

	// a fresh result follows an input transfer through the input and result registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without matching input transfer");

	// configuration writes are never stalled
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration channel stalled");

endmodule

bind pad_trigger_hysteresis_unit pth_checker u_pth_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.pad_id    (pad_id),
	.note_on   (note_on),
	.level     (level),
	.cfg_ready (cfg_ready)
);
